[rtl/core/u8u16_pkg.sv]
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder package
// Shared types and constants for the decoder front, point queue and unit back.
// ----------------------------------------------------------------------------
package u8u16_pkg;

   localparam int unsigned POINT_W = 21;
   localparam int unsigned UNIT_W  = 16;
   localparam int unsigned BYTE_W  = 8;

   localparam logic [POINT_W-1:0] REPLACEMENT_POINT  = 21'h00FFFD;
   localparam logic [POINT_W-1:0] SUPPLEMENTARY_BASE = 21'h010000;
   localparam logic [UNIT_W-1:0]  HIGH_SURROGATE     = 16'hD800;
   localparam logic [UNIT_W-1:0]  LOW_SURROGATE      = 16'hDC00;

   // Lead byte prefixes, compared against the top bits of the byte.
   localparam logic [2:0] LEAD2_PREFIX = 3'b110;
   localparam logic [3:0] LEAD3_PREFIX = 4'b1110;
   localparam logic [4:0] LEAD4_PREFIX = 5'b11110;

   // One finished code point, as handed from the front to the back.
   typedef struct packed {
      logic [POINT_W-1:0] cp;
      logic               text_end;
   } point_type;

endpackage

[rtl/core/u8u16_front.sv]
// ----------------------------------------------------------------------------
// UTF-8 decoder front
// Takes one byte per beat, gathers sequences and pushes finished code points.
// ----------------------------------------------------------------------------
module u8u16_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 queue_full,
   input  logic [7:0]           in_byte,
   input  logic                 text_end,
   output logic                 push,
   output u8u16_pkg::point_type push_point
);

   logic [u8u16_pkg::POINT_W-1:0] acc_ff, acc_in;
   logic [1:0]                    pend_ff, pend_in;
   logic                          accept;
   logic                          ready;
   logic [u8u16_pkg::POINT_W-1:0] cp;
   logic [1:0]                    pend_dec;

   assign accept   = req_valid && !queue_full;
   assign pend_dec = pend_ff - 2'd1;

   always_comb begin
      acc_in = acc_ff;
      pend_in = pend_ff;
      ready = 1'b0;
      cp = '0;
      if (pend_ff != 2'd0) begin
         // Every byte inside a sequence counts as a continuation byte.
         acc_in = {acc_ff[u8u16_pkg::POINT_W-7:0], in_byte[5:0]};
         pend_in = pend_dec;
         if (pend_dec == 2'd0 || text_end) begin
            cp = acc_in;
            ready = 1'b1;
         end
      end else if (!in_byte[7]) begin
         cp = {13'd0, in_byte};
         ready = 1'b1;
      end else if (in_byte[7:5] == u8u16_pkg::LEAD2_PREFIX) begin
         acc_in = {16'd0, in_byte[4:0]};
         pend_in = 2'd1;
      end else if (in_byte[7:4] == u8u16_pkg::LEAD3_PREFIX) begin
         acc_in = {17'd0, in_byte[3:0]};
         pend_in = 2'd2;
      end else if (in_byte[7:3] == u8u16_pkg::LEAD4_PREFIX) begin
         acc_in = {18'd0, in_byte[2:0]};
         pend_in = 2'd3;
      end else begin
         cp = u8u16_pkg::REPLACEMENT_POINT;
         ready = 1'b1;
      end

      // A text that ends inside a sequence flushes the partial value.
      if (!ready && text_end) begin
         cp = acc_in;
         ready = 1'b1;
      end

      if (ready) begin
         acc_in = '0;
         pend_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         pend_ff <= 2'd0;
      end else if (accept) begin
         acc_ff <= acc_in;
         pend_ff <= pend_in;
      end
   end

   assign push                = accept && ready;
   assign push_point.cp       = cp;
   assign push_point.text_end = text_end;

endmodule

[rtl/core/u8u16_queue.sv]
// ----------------------------------------------------------------------------
// Code point queue
// Small register queue that decouples the decoder front from the unit back.
// ----------------------------------------------------------------------------
module u8u16_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  u8u16_pkg::point_type push_point,
   input  logic                 pop,
   output logic                 full,
   output logic                 not_empty,
   output u8u16_pkg::point_type head
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   u8u16_pkg::point_type entry_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]     count_ff;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] result;
      if (ptr == PTR_W'(DEPTH - 1)) begin
         result = '0;
      end else begin
         result = ptr + PTR_W'(1);
      end
      return result;
   endfunction

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_point;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

[rtl/core/u8u16_back.sv]
// ----------------------------------------------------------------------------
// UTF-16 unit back
// Turns queued code points into one unit or a surrogate pair on the output.
// ----------------------------------------------------------------------------
module u8u16_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 queue_valid,
   input  u8u16_pkg::point_type head,
   output logic                 pop,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output logic [15:0]          rsp_code_unit,
   output logic                 rsp_run_last,
   output logic                 rsp_text_last
);

   logic        valid_ff, valid_in;
   logic [15:0] unit_ff, unit_in;
   logic        run_last_ff, run_last_in;
   logic        text_last_ff, text_last_in;
   logic        low_pend_ff, low_pend_in;
   logic [15:0] low_unit_ff, low_unit_in;
   logic        low_text_ff, low_text_in;
   logic        load;
   logic [u8u16_pkg::POINT_W-1:0] offset;
   logic [15:0] high_unit;
   logic [15:0] low_unit;

   assign load      = !valid_ff || !rsp_stall;
   assign offset    = head.cp - u8u16_pkg::SUPPLEMENTARY_BASE;
   assign high_unit = u8u16_pkg::HIGH_SURROGATE | {5'd0, offset[20:10]};
   assign low_unit  = u8u16_pkg::LOW_SURROGATE | {6'd0, offset[9:0]};

   always_comb begin
      valid_in = valid_ff;
      unit_in = unit_ff;
      run_last_in = run_last_ff;
      text_last_in = text_last_ff;
      low_pend_in = low_pend_ff;
      low_unit_in = low_unit_ff;
      low_text_in = low_text_ff;
      pop = 1'b0;
      if (load) begin
         if (low_pend_ff) begin
            valid_in = 1'b1;
            unit_in = low_unit_ff;
            run_last_in = 1'b1;
            text_last_in = low_text_ff;
            low_pend_in = 1'b0;
         end else if (queue_valid) begin
            pop = 1'b1;
            valid_in = 1'b1;
            if (head.cp >= u8u16_pkg::SUPPLEMENTARY_BASE) begin
               // High unit goes out now, the low unit waits one beat.
               unit_in = high_unit;
               run_last_in = 1'b0;
               text_last_in = 1'b0;
               low_pend_in = 1'b1;
               low_unit_in = low_unit;
               low_text_in = head.text_end;
            end else begin
               unit_in = head.cp[15:0];
               run_last_in = 1'b1;
               text_last_in = head.text_end;
            end
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         low_pend_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         low_pend_ff <= low_pend_in;
      end
      unit_ff <= unit_in;
      run_last_ff <= run_last_in;
      text_last_ff <= text_last_in;
      low_unit_ff <= low_unit_in;
      low_text_ff <= low_text_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_code_unit = unit_ff;
   assign rsp_run_last  = run_last_ff;
   assign rsp_text_last = text_last_ff;

endmodule

[rtl/core/utf8_to_utf16_transcoder_top.sv]
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder top level
// Byte-wide UTF-8 in, 16-bit UTF-16 code units out, valid/stall on both sides.
// ----------------------------------------------------------------------------
// Usage: the req channel moves one UTF-8 byte per beat together with a flag
// that marks the last byte of a text. The rsp channel moves one code unit per
// beat; run_last marks the last unit caused by one input byte and text_last
// the final unit of a text. A code point of 0x10000 or more becomes a surrogate
// pair, high unit first, in two consecutive beats.
// Throughput: one request byte per cycle while the queue has room. The output
// register sends one unit per cycle while rsp_stall is low, so a surrogate
// pair holds the back end while the decoder keeps filling the point queue.
// Path: the point enters the queue at the edge that takes its finishing byte,
// and the unit then enters the output register, which drives rsp; the low
// unit of a pair follows from the output register in the next beat.
// Stall: when the receiver stalls, the output register holds its beat, the
// queue fills, and req_stall rises once all QUEUE_DEPTH entries are taken.
// Reset: synchronous, active high; it clears the partial sequence, empties the
// queue and drops rsp_valid. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_top #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_text_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_code_unit,
   output logic        rsp_run_last,
   output logic        rsp_text_last
);

   logic                 push;
   logic                 pop;
   logic                 q_full;
   logic                 q_not_empty;
   u8u16_pkg::point_type push_point;
   u8u16_pkg::point_type head;

   // The decoder stalls only when the point queue has no room left.
   assign req_stall = q_full;

   u8u16_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .queue_full (q_full),
      .in_byte    (req_in_byte),
      .text_end   (req_text_end),
      .push       (push),
      .push_point (push_point)
   );

   u8u16_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_point (push_point),
      .pop        (pop),
      .full       (q_full),
      .not_empty  (q_not_empty),
      .head       (head)
   );

   u8u16_back u_back (
      .clock         (clock),
      .reset         (reset),
      .queue_valid   (q_not_empty),
      .head          (head),
      .pop           (pop),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_code_unit (rsp_code_unit),
      .rsp_run_last  (rsp_run_last),
      .rsp_text_last (rsp_text_last)
   );

   // The front must never write into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full)
      else $error("point pushed into a full queue");

   // The back must never take a point from an empty queue.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_not_empty)
      else $error("point popped from an empty queue");

   // The final unit of a text is always the last unit of its byte.
   a_text_last_run_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_text_last) |-> rsp_run_last)
      else $error("text_last without run_last");

   // Reset leaves no beat on the result channel.
   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat present right after reset");

endmodule
